// File: rtl/ealu_pkg.sv
// Shared types and operation codes for the eight-bit ALU with flags.
package ealu_pkg;

	localparam logic [4:0] FN_ADD  = 5'd0;
	localparam logic [4:0] FN_ADC  = 5'd1;
	localparam logic [4:0] FN_SUB  = 5'd2;
	localparam logic [4:0] FN_SBC  = 5'd3;
	localparam logic [4:0] FN_AND  = 5'd4;
	localparam logic [4:0] FN_XOR  = 5'd5;
	localparam logic [4:0] FN_OR   = 5'd6;
	localparam logic [4:0] FN_CP   = 5'd7;
	localparam logic [4:0] FN_INC  = 5'd8;
	localparam logic [4:0] FN_DEC  = 5'd9;
	localparam logic [4:0] FN_DAA  = 5'd10;
	localparam logic [4:0] FN_CPL  = 5'd11;
	localparam logic [4:0] FN_CCF  = 5'd12;
	localparam logic [4:0] FN_SCF  = 5'd13;
	localparam logic [4:0] FN_SL0  = 5'd14;
	localparam logic [4:0] FN_SL1  = 5'd15;
	localparam logic [4:0] FN_SLC  = 5'd16;
	localparam logic [4:0] FN_SLR  = 5'd17;
	localparam logic [4:0] FN_SRA  = 5'd18;
	localparam logic [4:0] FN_SR0  = 5'd19;
	localparam logic [4:0] FN_SRC  = 5'd20;
	localparam logic [4:0] FN_SRR  = 5'd21;

	localparam logic [7:0] DAA_LOW_ADJ  = 8'h06;
	localparam logic [7:0] DAA_HIGH_ADJ = 8'h60;
	localparam logic [7:0] DAA_HIGH_LIM = 8'h99;
	localparam logic [3:0] DAA_LOW_LIM  = 4'h9;

	typedef struct packed {
		logic [4:0] func;
		logic [7:0] operand_a;
		logic [7:0] operand_b;
		logic       zero_in;
		logic       subtract_in;
		logic       half_in;
		logic       carry_in;
		logic       accumulator_form;
	} ealu_req_t;

	typedef struct packed {
		logic [7:0] result;
		logic       zero_out;
		logic       subtract_out;
		logic       half_out;
		logic       carry_out;
		logic       write_back;
	} ealu_rsp_t;

endpackage

// File: rtl/ealu_chan_if.sv
// Valid/ready channel carrying one word of a given payload type.
interface ealu_chan_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// File: rtl/ealu_core.sv
// Combinational datapath: result byte, flags and write-back mark for one operation.
module ealu_core (
	input  ealu_pkg::ealu_req_t req,
	output ealu_pkg::ealu_rsp_t rsp
);

	logic [7:0] a;
	logic [7:0] b;
	logic       cin;
	logic [8:0] sum9;
	logic [4:0] sum_lo;
	logic [8:0] dif9;
	logic [4:0] dif_lo;
	logic [7:0] inc8;
	logic [7:0] dec8;
	logic [7:0] daa_t;
	logic       daa_c;
	logic [7:0] r;
	logic       z;
	logic       n;
	logic       h;
	logic       c;
	logic       wb;

	assign a   = req.operand_a;
	assign b   = req.operand_b;
	assign cin = (req.func == ealu_pkg::FN_ADC || req.func == ealu_pkg::FN_SBC) ?
		req.carry_in : 1'b0;

	assign sum9   = {1'b0, a} + {1'b0, b} + {8'd0, cin};
	assign sum_lo = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'd0, cin};
	assign dif9   = {1'b0, a} - {1'b0, b} - {8'd0, cin};
	assign dif_lo = {1'b0, a[3:0]} - {1'b0, b[3:0]} - {4'd0, cin};
	assign inc8   = a + 8'd1;
	assign dec8   = a - 8'd1;

	always_comb begin
		daa_t = a;
		daa_c = req.carry_in;
		if (!req.subtract_in) begin
			if (req.carry_in || a > ealu_pkg::DAA_HIGH_LIM) begin
				daa_t = daa_t + ealu_pkg::DAA_HIGH_ADJ;
				daa_c = 1'b1;
			end
			if (req.half_in || daa_t[3:0] > ealu_pkg::DAA_LOW_LIM) begin
				daa_t = daa_t + ealu_pkg::DAA_LOW_ADJ;
			end
		end else begin
			if (req.carry_in) begin
				daa_t = daa_t - ealu_pkg::DAA_HIGH_ADJ;
			end
			if (req.half_in) begin
				daa_t = daa_t - ealu_pkg::DAA_LOW_ADJ;
			end
		end
	end

	always_comb begin
		r  = a;
		z  = req.zero_in;
		n  = req.subtract_in;
		h  = req.half_in;
		c  = req.carry_in;
		wb = 1'b1;
		case (req.func)
			ealu_pkg::FN_ADD, ealu_pkg::FN_ADC: begin
				r = sum9[7:0];
				z = (sum9[7:0] == 8'd0);
				n = 1'b0;
				h = sum_lo[4];
				c = sum9[8];
			end
			ealu_pkg::FN_SUB, ealu_pkg::FN_SBC, ealu_pkg::FN_CP: begin
				r  = (req.func == ealu_pkg::FN_CP) ? a : dif9[7:0];
				wb = (req.func != ealu_pkg::FN_CP);
				z  = (dif9[7:0] == 8'd0);
				n  = 1'b1;
				h  = dif_lo[4];
				c  = dif9[8];
			end
			ealu_pkg::FN_AND: begin
				r = a & b;
				z = ((a & b) == 8'd0);
				n = 1'b0;
				h = 1'b1;
				c = 1'b0;
			end
			ealu_pkg::FN_XOR: begin
				r = a ^ b;
				z = ((a ^ b) == 8'd0);
				n = 1'b0;
				h = 1'b0;
				c = 1'b0;
			end
			ealu_pkg::FN_OR: begin
				r = a | b;
				z = ((a | b) == 8'd0);
				n = 1'b0;
				h = 1'b0;
				c = 1'b0;
			end
			ealu_pkg::FN_INC: begin
				r = inc8;
				z = (inc8 == 8'd0);
				n = 1'b0;
				h = (inc8[3:0] == 4'h0);
			end
			ealu_pkg::FN_DEC: begin
				r = dec8;
				z = (dec8 == 8'd0);
				n = 1'b1;
				h = (dec8[3:0] == 4'hf);
			end
			ealu_pkg::FN_DAA: begin
				r = daa_t;
				z = (daa_t == 8'd0);
				h = 1'b0;
				c = daa_c;
			end
			ealu_pkg::FN_CPL: begin
				r = ~a;
				n = 1'b1;
				h = 1'b1;
			end
			ealu_pkg::FN_CCF, ealu_pkg::FN_SCF: begin
				n  = 1'b0;
				h  = 1'b0;
				c  = (req.func == ealu_pkg::FN_CCF) ? ~req.carry_in : 1'b1;
				wb = 1'b0;
			end
			ealu_pkg::FN_SL0, ealu_pkg::FN_SL1, ealu_pkg::FN_SLC, ealu_pkg::FN_SLR: begin
				case (req.func)
					ealu_pkg::FN_SL0: r = {a[6:0], 1'b0};
					ealu_pkg::FN_SL1: r = {a[6:0], 1'b1};
					ealu_pkg::FN_SLC: r = {a[6:0], req.carry_in};
					default:          r = {a[6:0], a[7]};
				endcase
				z = !req.accumulator_form && (r == 8'd0);
				n = 1'b0;
				h = 1'b0;
				c = a[7];
			end
			ealu_pkg::FN_SRA, ealu_pkg::FN_SR0, ealu_pkg::FN_SRC, ealu_pkg::FN_SRR: begin
				case (req.func)
					ealu_pkg::FN_SRA: r = {a[7], a[7:1]};
					ealu_pkg::FN_SR0: r = {1'b0, a[7:1]};
					ealu_pkg::FN_SRC: r = {req.carry_in, a[7:1]};
					default:          r = {a[0], a[7:1]};
				endcase
				z = !req.accumulator_form && (r == 8'd0);
				n = 1'b0;
				h = 1'b0;
				c = a[0];
			end
			default: begin
				wb = 1'b0;
			end
		endcase
	end

	assign rsp.result       = r;
	assign rsp.zero_out     = z;
	assign rsp.subtract_out = n;
	assign rsp.half_out     = h;
	assign rsp.carry_out    = c;
	assign rsp.write_back   = wb;

endmodule

// File: rtl/eight_bit_alu_with_flags_unit.sv
// Top level of the eight-bit ALU with flags: input register, datapath, result register.
//
//   channel  dir  payload
//   req      in   func, operand_a, operand_b, zero_in, subtract_in, half_in,
//                 carry_in, accumulator_form
//   rsp      out  result, zero_out, subtract_out, half_out, carry_out, write_back
//
// One word in and one word out per cycle while rsp does not stall; a word taken on req
// is held in the input register, passes the datapath into the result register and is
// then offered on rsp.
// arst_n clears both stage valid bits; payload registers are not reset.
// A stall on rsp holds the result register, and the input register keeps taking
// words as long as either stage has room.
module eight_bit_alu_with_flags_unit (
	input logic         clk,
	input logic         arst_n,
	ealu_chan_if.sink   req,
	ealu_chan_if.source rsp
);

	ealu_pkg::ealu_req_t req_s1;
	ealu_pkg::ealu_rsp_t core_rsp;
	ealu_pkg::ealu_rsp_t rsp_s2;
	logic                vld_s1;
	logic                vld_s2;
	logic                adv_s2;

	assign adv_s2    = !vld_s2 || rsp.ready;
	assign req.ready = !vld_s1 || adv_s2;

	ealu_core u_core (
		.req (req_s1),
		.rsp (core_rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			if (req.ready) begin
				vld_s1 <= req.valid;
			end
			if (adv_s2) begin
				vld_s2 <= vld_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			req_s1 <= req.data;
		end
		if (adv_s2 && vld_s1) begin
			rsp_s2 <= core_rsp;
		end
	end

	assign rsp.valid = vld_s2;
	assign rsp.data  = rsp_s2;

	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!vld_s1 |-> req.ready)
		else $error("input stage empty but not ready");

	a_accept_fills_s1: assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready) |=> vld_s1)
		else $error("accepted word lost at input stage");

	a_s1_moves_to_s2: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s1 && adv_s2) |=> (vld_s2 && rsp_s2 == $past(core_rsp)))
		else $error("result register did not capture datapath output");

	a_s1_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s1 && !adv_s2) |=> (vld_s1 && $stable(req_s1)))
		else $error("input stage changed while blocked");

endmodule
